// ----- rtl/mhp_pkg.sv -----
// ----------------------------------------------------------------------------
// mhp_pkg - shared types and constants of the metrics header parser
// Widths, status codes, character classes, the known-key table and the
// word carried between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package mhp_pkg;

  localparam int NUM_METRICS = 9;
  localparam int VAL_W       = 30;
  localparam int LEN_W       = 12;
  localparam int STATUS_W    = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int DIGIT_CNT_W = 4;
  localparam int KEY_W       = 16;

  localparam int MAX_DIGITS      = 9;
  localparam int DIGIT_CNT_LIMIT = 10;

  localparam logic [LEN_W-1:0] MAX_LEN_RST        = 12'd256;
  localparam logic [VAL_W-1:0] PAGE_LOAD_CEIL_RST = 30'd600000;
  localparam logic [VAL_W-1:0] COUNT_CEIL_RST     = 30'd1000000;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Metric lanes, in key-table order
  localparam int IDX_PAGE_LOAD  = 0;
  localparam int IDX_CACHE_HIT  = 1;
  localparam int IDX_CACHE_MISS = 2;
  localparam int IDX_UNCAUGHT   = 3;
  localparam int IDX_API_ERR    = 4;
  localparam int IDX_WAITS      = 5;
  localparam int IDX_SLOW_WAITS = 6;
  localparam int IDX_VER_RELOAD = 7;
  localparam int IDX_VER_STUCK  = 8;

  // pl ch cm ee ea wn ws vr vs, first byte in the upper half
  localparam logic [KEY_W-1:0] KEY_TABLE [NUM_METRICS] = '{
    16'h706C, 16'h6368, 16'h636D, 16'h6565, 16'h6561,
    16'h776E, 16'h7773, 16'h7672, 16'h7673
  };

  typedef logic [VAL_W-1:0] metric_t;

  typedef enum logic [2:0] {
    FAIL_NONE       = 3'd0,
    FAIL_TOO_LONG   = 3'd1,
    FAIL_NO_EQUALS  = 3'd2,
    FAIL_EMPTY_KEY  = 3'd3,
    FAIL_BAD_VALUE  = 3'd4,
    FAIL_REPEAT     = 3'd5,
    FAIL_OVER_CEIL  = 3'd6,
    FAIL_SLOW_WAITS = 3'd7
  } fail_t;

  typedef enum logic [1:0] {
    CLS_COMMA,
    CLS_EQUALS,
    CLS_DIGIT,
    CLS_OTHER
  } char_cls_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LEN        = 2'd0,
    REG_PAGE_LOAD_CEIL = 2'd1,
    REG_COUNT_CEIL     = 2'd2
  } cfg_reg_t;

  // Classified header byte, front end to back end
  typedef struct packed {
    logic [7:0] ch;
    char_cls_t  cls;
    logic       is_last;
    logic       too_long;
  } byte_item_t;

endpackage

`default_nettype wire

// ----- rtl/mhp_in_if.sv -----
// ----------------------------------------------------------------------------
// mhp_in_if - header byte channel
// Valid/ready channel carrying one header byte and its end marker.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_last;

  modport source (output valid, output char_in, output is_last, input ready);
  modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/mhp_out_if.sv -----
// ----------------------------------------------------------------------------
// mhp_out_if - report channel
// Valid/ready channel carrying one header report: status and nine metrics.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [mhp_pkg::STATUS_W-1:0]          status;
  logic [mhp_pkg::VAL_W-1:0]             page_load_ms;
  logic [mhp_pkg::VAL_W-1:0]             cache_hits;
  logic [mhp_pkg::VAL_W-1:0]             cache_misses;
  logic [mhp_pkg::VAL_W-1:0]             uncaught_errors;
  logic [mhp_pkg::VAL_W-1:0]             api_errors;
  logic [mhp_pkg::VAL_W-1:0]             position_waits;
  logic [mhp_pkg::VAL_W-1:0]             slow_position_waits;
  logic [mhp_pkg::VAL_W-1:0]             version_reloads;
  logic [mhp_pkg::VAL_W-1:0]             version_stuck;

  modport source (
    output valid, output status, output page_load_ms, output cache_hits,
    output cache_misses, output uncaught_errors, output api_errors,
    output position_waits, output slow_position_waits, output version_reloads,
    output version_stuck, input ready
  );
  modport sink (
    input valid, input status, input page_load_ms, input cache_hits,
    input cache_misses, input uncaught_errors, input api_errors,
    input position_waits, input slow_position_waits, input version_reloads,
    input version_stuck, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/mhp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mhp_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mhp_pkg::CFG_IDX_W-1:0] index;
  logic [mhp_pkg::VAL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/mhp_front.sv -----
// ----------------------------------------------------------------------------
// mhp_front - byte intake and classification
// Counts header bytes, flags bytes past the length limit and sorts each byte
// into comma, equals, digit or other before queueing it.
// ----------------------------------------------------------------------------
`default_nettype none

module mhp_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  mhp_in_if.sink                            in_ch,
  input  wire logic [mhp_pkg::LEN_W-1:0]    max_len,
  output      logic                         push,
  output      mhp_pkg::byte_item_t          push_item,
  input  wire logic                         push_ready
);

  logic [mhp_pkg::LEN_W-1:0] byte_cnt_r;
  logic [mhp_pkg::LEN_W-1:0] byte_cnt_nxt;
  logic [mhp_pkg::LEN_W:0]   cnt_plus_one;

  assign in_ch.ready  = push_ready;
  assign push         = in_ch.valid && push_ready;
  assign cnt_plus_one = {1'b0, byte_cnt_r} + {{mhp_pkg::LEN_W{1'b0}}, 1'b1};

  always_comb begin
    push_item.ch       = in_ch.char_in;
    push_item.is_last  = in_ch.is_last;
    push_item.too_long = cnt_plus_one > {1'b0, max_len};
    if (in_ch.char_in == mhp_pkg::CH_COMMA) begin
      push_item.cls = mhp_pkg::CLS_COMMA;
    end else if (in_ch.char_in == mhp_pkg::CH_EQUALS) begin
      push_item.cls = mhp_pkg::CLS_EQUALS;
    end else if (in_ch.char_in >= mhp_pkg::CH_ZERO && in_ch.char_in <= mhp_pkg::CH_NINE) begin
      push_item.cls = mhp_pkg::CLS_DIGIT;
    end else begin
      push_item.cls = mhp_pkg::CLS_OTHER;
    end
  end

  // Restart at each header end, otherwise count and saturate
  always_comb begin
    byte_cnt_nxt = byte_cnt_r;
    if (push) begin
      if (in_ch.is_last) begin
        byte_cnt_nxt = '0;
      end else if (byte_cnt_r != '1) begin
        byte_cnt_nxt = cnt_plus_one[mhp_pkg::LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_cnt_r <= '0;
    end else begin
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mhp_queue.sv -----
// ----------------------------------------------------------------------------
// mhp_queue - classified byte queue
// Small FIFO between front end and back end so that each may stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module mhp_queue #(
  parameter int DEPTH = mhp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mhp_pkg::byte_item_t push_item,
  output      logic                push_ready,
  output      logic                pop_valid,
  output      mhp_pkg::byte_item_t pop_item,
  input  wire logic                pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mhp_pkg::byte_item_t slot_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mhp_back.sv -----
// ----------------------------------------------------------------------------
// mhp_back - pair parser and report stages
// Walks key=value pairs, checks and stores the known metrics, then hands the
// header result through a report stage and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhp_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      item_valid,
  input  wire mhp_pkg::byte_item_t       item,
  output      logic                      item_pop,
  input  wire logic [mhp_pkg::VAL_W-1:0] page_load_ceil,
  input  wire logic [mhp_pkg::VAL_W-1:0] count_ceil,
  mhp_out_if.source                      out_ch
);

  localparam int NM = mhp_pkg::NUM_METRICS;
  localparam int CW = mhp_pkg::DIGIT_CNT_W;

  // Parse state
  logic                          in_value_r, in_value_nxt;
  logic [mhp_pkg::KEY_W-1:0]     key_chars_r, key_chars_nxt;
  logic [1:0]                    key_len_r, key_len_nxt;
  mhp_pkg::metric_t              total_r, total_nxt;
  logic [CW-1:0]                 digit_cnt_r, digit_cnt_nxt;
  logic [NM-1:0]                 seen_r, seen_nxt;
  mhp_pkg::metric_t              metric_r [NM];
  mhp_pkg::metric_t              metric_nxt [NM];
  mhp_pkg::fail_t                fail_r, fail_nxt;

  // Report stage and output register
  logic                          rep_valid_r, rep_valid_nxt;
  mhp_pkg::fail_t                rep_fail_r;
  mhp_pkg::metric_t              rep_metric_r [NM];
  logic                          out_valid_r, out_valid_nxt;
  mhp_pkg::fail_t                out_fail_r, out_fail_nxt;
  mhp_pkg::metric_t              out_metric_r [NM];

  logic                          rep_adv, rep_free, pop;
  logic                          is_comma, slow_over;

  // Byte step
  mhp_pkg::fail_t                fail0, fail_tk, fail_ep, fail_fin;
  logic                          iv_tk;
  logic [mhp_pkg::KEY_W-1:0]     kc_tk;
  logic [1:0]                    kl_tk;
  mhp_pkg::metric_t              tot_tk;
  logic [CW-1:0]                 cnt_tk;
  logic [mhp_pkg::VAL_W+3:0]     acc;

  // End of pair
  logic                          v_iv;
  logic [mhp_pkg::KEY_W-1:0]     v_kc;
  logic [1:0]                    v_kl;
  mhp_pkg::metric_t              v_tot;
  logic [CW-1:0]                 v_cnt;
  logic [NM-1:0]                 hit, seen_ep;
  logic                          ep_en, wr_en;
  mhp_pkg::metric_t              ceiling;

  assign rep_adv  = rep_valid_r && (!out_valid_r || out_ch.ready);
  assign rep_free = !rep_valid_r || rep_adv;
  assign pop      = item_valid && (!item.is_last || rep_free);
  assign item_pop = pop;
  assign is_comma = item.cls == mhp_pkg::CLS_COMMA;

  assign acc = ({4'b0, total_r} << 3) + ({4'b0, total_r} << 1)
             + {{mhp_pkg::VAL_W{1'b0}}, item.ch[3:0]};

  // Apply one non-comma byte to the pair being read
  always_comb begin
    fail0   = item.too_long ? mhp_pkg::FAIL_TOO_LONG : fail_r;
    fail_tk = fail0;
    iv_tk   = in_value_r;
    kc_tk   = key_chars_r;
    kl_tk   = key_len_r;
    tot_tk  = total_r;
    cnt_tk  = digit_cnt_r;
    if (fail0 == mhp_pkg::FAIL_NONE) begin
      case (item.cls)
        mhp_pkg::CLS_COMMA: begin
          fail_tk = fail0;
        end
        mhp_pkg::CLS_EQUALS: begin
          if (!in_value_r) begin
            iv_tk = 1'b1;
            if (key_len_r == 2'd0) begin
              fail_tk = mhp_pkg::FAIL_EMPTY_KEY;
            end
          end else begin
            fail_tk = mhp_pkg::FAIL_BAD_VALUE;
          end
        end
        mhp_pkg::CLS_DIGIT: begin
          if (!in_value_r) begin
            if (key_len_r < 2'd2) begin
              kc_tk = {key_chars_r[7:0], item.ch};
            end
            if (key_len_r != 2'd3) begin
              kl_tk = key_len_r + 2'd1;
            end
          end else begin
            if (digit_cnt_r < CW'(mhp_pkg::MAX_DIGITS)) begin
              tot_tk = acc[mhp_pkg::VAL_W-1:0];
            end
            if (digit_cnt_r < CW'(mhp_pkg::DIGIT_CNT_LIMIT)) begin
              cnt_tk = digit_cnt_r + 1'b1;
            end
            if (cnt_tk > CW'(mhp_pkg::MAX_DIGITS)) begin
              fail_tk = mhp_pkg::FAIL_BAD_VALUE;
            end
          end
        end
        default: begin
          if (!in_value_r) begin
            if (key_len_r < 2'd2) begin
              kc_tk = {key_chars_r[7:0], item.ch};
            end
            if (key_len_r != 2'd3) begin
              kl_tk = key_len_r + 2'd1;
            end
          end else begin
            fail_tk = mhp_pkg::FAIL_BAD_VALUE;
          end
        end
      endcase
    end
  end

  // Close a pair: on a comma the stored pair, at header end the updated one
  always_comb begin
    v_iv  = is_comma ? in_value_r  : iv_tk;
    v_kc  = is_comma ? key_chars_r : kc_tk;
    v_kl  = is_comma ? key_len_r   : kl_tk;
    v_tot = is_comma ? total_r     : tot_tk;
    v_cnt = is_comma ? digit_cnt_r : cnt_tk;
    for (int i = 0; i < NM; i++) begin
      hit[i] = (v_kl == 2'd2) && (v_kc == mhp_pkg::KEY_TABLE[i]);
    end
    ceiling = hit[mhp_pkg::IDX_PAGE_LOAD] ? page_load_ceil : count_ceil;
    ep_en   = (is_comma || item.is_last) && (fail_tk == mhp_pkg::FAIL_NONE);
    fail_ep = fail_tk;
    seen_ep = seen_r;
    wr_en   = 1'b0;
    if (ep_en) begin
      if (!v_iv) begin
        fail_ep = mhp_pkg::FAIL_NO_EQUALS;
      end else if (v_cnt == '0) begin
        fail_ep = mhp_pkg::FAIL_BAD_VALUE;
      end else if (hit != '0) begin
        if ((seen_r & hit) != '0) begin
          fail_ep = mhp_pkg::FAIL_REPEAT;
        end else begin
          seen_ep = seen_r | hit;
          if (v_tot > ceiling) begin
            fail_ep = mhp_pkg::FAIL_OVER_CEIL;
          end else begin
            wr_en = 1'b1;
          end
        end
      end
    end
    // A trailing comma leaves an empty pair with no equals sign
    fail_fin = fail_ep;
    if (is_comma && item.is_last && fail_ep == mhp_pkg::FAIL_NONE) begin
      fail_fin = mhp_pkg::FAIL_NO_EQUALS;
    end
    for (int i = 0; i < NM; i++) begin
      metric_nxt[i] = (wr_en && hit[i]) ? v_tot : metric_r[i];
    end
  end

  always_comb begin
    in_value_nxt  = in_value_r;
    key_chars_nxt = key_chars_r;
    key_len_nxt   = key_len_r;
    total_nxt     = total_r;
    digit_cnt_nxt = digit_cnt_r;
    seen_nxt      = seen_r;
    fail_nxt      = fail_r;
    if (pop) begin
      if (item.is_last || is_comma) begin
        in_value_nxt  = 1'b0;
        key_chars_nxt = '0;
        key_len_nxt   = '0;
        total_nxt     = '0;
        digit_cnt_nxt = '0;
      end else begin
        in_value_nxt  = iv_tk;
        key_chars_nxt = kc_tk;
        key_len_nxt   = kl_tk;
        total_nxt     = tot_tk;
        digit_cnt_nxt = cnt_tk;
      end
      if (item.is_last) begin
        seen_nxt = '0;
        fail_nxt = mhp_pkg::FAIL_NONE;
      end else begin
        seen_nxt = seen_ep;
        fail_nxt = fail_fin;
      end
    end
  end

  always_comb begin
    rep_valid_nxt = rep_valid_r;
    if (pop && item.is_last) begin
      rep_valid_nxt = 1'b1;
    end else if (rep_adv) begin
      rep_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (rep_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign slow_over = rep_metric_r[mhp_pkg::IDX_SLOW_WAITS] > rep_metric_r[mhp_pkg::IDX_WAITS];
  assign out_fail_nxt = (rep_fail_r == mhp_pkg::FAIL_NONE && slow_over) ?
                        mhp_pkg::FAIL_SLOW_WAITS : rep_fail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_r  <= 1'b0;
      key_chars_r <= '0;
      key_len_r   <= '0;
      total_r     <= '0;
      digit_cnt_r <= '0;
      seen_r      <= '0;
      fail_r      <= mhp_pkg::FAIL_NONE;
      rep_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NM; i++) begin
        metric_r[i] <= '0;
      end
    end else begin
      in_value_r  <= in_value_nxt;
      key_chars_r <= key_chars_nxt;
      key_len_r   <= key_len_nxt;
      total_r     <= total_nxt;
      digit_cnt_r <= digit_cnt_nxt;
      seen_r      <= seen_nxt;
      fail_r      <= fail_nxt;
      rep_valid_r <= rep_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        for (int i = 0; i < NM; i++) begin
          metric_r[i] <= item.is_last ? '0 : metric_nxt[i];
        end
      end
    end
  end

  // Report payloads: snapshot at header end, then the output register
  always_ff @(posedge clk) begin
    if (pop && item.is_last) begin
      rep_fail_r <= fail_fin;
      for (int i = 0; i < NM; i++) begin
        rep_metric_r[i] <= metric_nxt[i];
      end
    end
    if (rep_adv) begin
      out_fail_r <= out_fail_nxt;
      for (int i = 0; i < NM; i++) begin
        out_metric_r[i] <= (out_fail_nxt == mhp_pkg::FAIL_NONE) ? rep_metric_r[i] : '0;
      end
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.status              = {1'b0, out_fail_r};
  assign out_ch.page_load_ms        = out_metric_r[mhp_pkg::IDX_PAGE_LOAD];
  assign out_ch.cache_hits          = out_metric_r[mhp_pkg::IDX_CACHE_HIT];
  assign out_ch.cache_misses        = out_metric_r[mhp_pkg::IDX_CACHE_MISS];
  assign out_ch.uncaught_errors     = out_metric_r[mhp_pkg::IDX_UNCAUGHT];
  assign out_ch.api_errors          = out_metric_r[mhp_pkg::IDX_API_ERR];
  assign out_ch.position_waits      = out_metric_r[mhp_pkg::IDX_WAITS];
  assign out_ch.slow_position_waits = out_metric_r[mhp_pkg::IDX_SLOW_WAITS];
  assign out_ch.version_reloads     = out_metric_r[mhp_pkg::IDX_VER_RELOAD];
  assign out_ch.version_stuck       = out_metric_r[mhp_pkg::IDX_VER_STUCK];

  // Header end leaves a clean slate for the next header
  a_header_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && item.is_last |=> !in_value_r && seen_r == '0 && fail_r == mhp_pkg::FAIL_NONE)
    else $error("parse state not cleared after header end");

  // A byte past the length limit pins the header to too-long
  a_too_long_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !item.is_last && item.too_long |=> fail_r == mhp_pkg::FAIL_TOO_LONG)
    else $error("too-long byte did not set failure");

  // The wait check belongs to the report stage only
  a_no_slow_in_parser: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r != mhp_pkg::FAIL_SLOW_WAITS)
    else $error("slow-wait failure reached parse state");

  // A held report is neither lost nor has its status altered
  a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rep_valid_r && !rep_adv |=> rep_valid_r && $stable(rep_fail_r))
    else $error("pending report dropped or changed");

endmodule

`default_nettype wire

// ----- rtl/metrics_header_parser.sv -----
// ----------------------------------------------------------------------------
// metrics_header_parser - key=value metrics header parser
// Top level: configuration registers, front end, byte queue and back end.
// ----------------------------------------------------------------------------
// The block takes a comma-separated key=value header one byte per word on
// in_ch and gives one report word on out_ch for the byte marked is_last:
// a status code and the nine metrics (all zero unless the status is ok).
// It sustains one header byte per clock cycle as long as out_ch accepts
// reports; the limit is the back end's pair parser, which handles one byte
// a cycle with a single decimal multiply-accumulate, the key compares and
// one ceiling compare. A report passes from its last byte through the queue,
// the report stage and the output register, while bytes of the next header
// keep flowing in behind it. The queue holds QUEUE_DEPTH classified bytes,
// so intake and parsing stall independently. Configuration writes on cfg_ch
// are always taken and must only be made while no header is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module metrics_header_parser #(
  parameter int QUEUE_DEPTH = mhp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mhp_in_if.sink    in_ch,
  mhp_out_if.source out_ch,
  mhp_cfg_if.sink   cfg_ch
);

  // Configuration registers
  logic [mhp_pkg::LEN_W-1:0] max_len_r, max_len_nxt;
  mhp_pkg::metric_t          pl_ceil_r, pl_ceil_nxt;
  mhp_pkg::metric_t          cnt_ceil_r, cnt_ceil_nxt;

  // Front end to queue
  logic                      push;
  logic                      push_ready;
  mhp_pkg::byte_item_t       push_item;

  // Queue to back end
  logic                      q_valid;
  logic                      q_pop;
  mhp_pkg::byte_item_t       q_item;

  // Writes are never back-pressured; an unknown index is dropped
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    max_len_nxt  = max_len_r;
    pl_ceil_nxt  = pl_ceil_r;
    cnt_ceil_nxt = cnt_ceil_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        mhp_pkg::REG_MAX_LEN: begin
          max_len_nxt = cfg_ch.data[mhp_pkg::LEN_W-1:0];
        end
        mhp_pkg::REG_PAGE_LOAD_CEIL: begin
          pl_ceil_nxt = cfg_ch.data;
        end
        mhp_pkg::REG_COUNT_CEIL: begin
          cnt_ceil_nxt = cfg_ch.data;
        end
        default: begin
          max_len_nxt = max_len_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r  <= mhp_pkg::MAX_LEN_RST;
      pl_ceil_r  <= mhp_pkg::PAGE_LOAD_CEIL_RST;
      cnt_ceil_r <= mhp_pkg::COUNT_CEIL_RST;
    end else begin
      max_len_r  <= max_len_nxt;
      pl_ceil_r  <= pl_ceil_nxt;
      cnt_ceil_r <= cnt_ceil_nxt;
    end
  end

  // Count and classify each incoming word
  mhp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .max_len    (max_len_r),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // Decouple intake from parsing
  mhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  // Parse pairs and deliver the report
  mhp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_valid     (q_valid),
    .item           (q_item),
    .item_pop       (q_pop),
    .page_load_ceil (pl_ceil_r),
    .count_ceil     (cnt_ceil_r),
    .out_ch         (out_ch)
  );

endmodule

`default_nettype wire
